// ----- rtl/core/dlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dlpm_pkg
// Shared constants of the doubly linked pool manager: default pool depth,
// command codes and status codes.
// ----------------------------------------------------------------------------
package dlpm_pkg;

   localparam int DEF_POOL_DEPTH = 256;

   localparam logic [2:0] CMD_ALLOC      = 3'd0;
   localparam logic [2:0] CMD_PREPEND    = 3'd1;
   localparam logic [2:0] CMD_APPEND     = 3'd2;
   localparam logic [2:0] CMD_INS_BEFORE = 3'd3;
   localparam logic [2:0] CMD_INS_AFTER  = 3'd4;
   localparam logic [2:0] CMD_FREE       = 3'd5;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
   localparam logic [1:0] STAT_BAD_TGT   = 2'd2;

endpackage

// ----- rtl/core/dlpm_link_ram.sv -----
// ----------------------------------------------------------------------------
// dlpm_link_ram
// Link tables of the pool: a next memory holding {in_use, next} and a prev
// memory. One shared read address, registered read data, one write each.
// ----------------------------------------------------------------------------
module dlpm_link_ram #(
   parameter int POOL_DEPTH = dlpm_pkg::DEF_POOL_DEPTH
) (
   input  logic                                clock,
   input  logic [$clog2(POOL_DEPTH)-1:0]       rd_addr,
   output logic                                rd_use,
   output logic [$clog2(POOL_DEPTH+1)-1:0]     rd_next,
   output logic [$clog2(POOL_DEPTH+1)-1:0]     rd_prev,
   input  logic                                nw_en,
   input  logic [$clog2(POOL_DEPTH)-1:0]       nw_addr,
   input  logic                                nw_use,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]     nw_next,
   input  logic                                pw_en,
   input  logic [$clog2(POOL_DEPTH)-1:0]       pw_addr,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]     pw_prev
);
   import dlpm_pkg::*;

   localparam int NW = $clog2(POOL_DEPTH+1);

   logic [NW:0]   next_mem [POOL_DEPTH];
   logic [NW-1:0] prev_mem [POOL_DEPTH];

   always_ff @(posedge clock) begin
      if (nw_en) begin
         next_mem[nw_addr] <= {nw_use, nw_next};
      end
      {rd_use, rd_next} <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pw_en) begin
         prev_mem[pw_addr] <= pw_prev;
      end
      rd_prev <= prev_mem[rd_addr];
   end

endmodule

// ----- rtl/core/doubly_linked_pool_manager.sv -----
// Throughput: one command at a time; an append first walks the list to its tail.
//   The next command is accepted once the result is registered, which waits while
//   a held response is not yet taken; set by the one read port of the link memories.
// Reset: synchronous; a clearing pass then builds the free chain in index order,
//   during which no command is accepted.
// ----------------------------------------------------------------------------
// doubly_linked_pool_manager
// Pool of list nodes with a free chain; allocate, prepend, append, insert
// before/after and free, sequenced over a pair of link memories.
// ----------------------------------------------------------------------------
module doubly_linked_pool_manager #(
   parameter int POOL_DEPTH = dlpm_pkg::DEF_POOL_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_cmd,
   input  logic [$clog2(POOL_DEPTH+1)-1:0] req_head,
   input  logic [$clog2(POOL_DEPTH+1)-1:0] req_target,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [$clog2(POOL_DEPTH+1)-1:0] rsp_entry,
   output logic [$clog2(POOL_DEPTH+1)-1:0] rsp_new_head,
   output logic [1:0]                      rsp_status,
   output logic [$clog2(POOL_DEPTH+1)-1:0] rsp_entry_next,
   output logic [$clog2(POOL_DEPTH+1)-1:0] rsp_entry_prev
);
   import dlpm_pkg::*;

   localparam int NW = $clog2(POOL_DEPTH+1);
   localparam int AW = $clog2(POOL_DEPTH);
   localparam logic [NW-1:0] NIL = NW'(POOL_DEPTH);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_RD_HEAD, ST_RD_TGT, ST_DECIDE, ST_WALK, ST_WR_R,
      ST_WR_P, ST_RMW_RD, ST_RMW_WR, ST_FREE_TG, ST_DONE
   } state_type;

   state_type     state_ff;
   logic [NW-1:0] cnt_ff;
   logic [NW-1:0] free_head_ff;
   logic [2:0]    cmd_ff;
   logic [NW-1:0] hd_ff, tg_ff, eh_ff, tn_ff, tp_ff, r_ff, last_ff;
   logic          tok_ff;
   logic [1:0]    st_ff;
   logic [NW-1:0] rnext_ff, rprev_ff, pw_addr_ff, pw_val_ff, mw_addr_ff, mw_val_ff;
   logic          rsp_valid_ff;
   logic [NW-1:0] rsp_entry_ff, rsp_new_head_ff, rsp_next_ff, rsp_prev_ff;
   logic [1:0]    rsp_status_ff;

   logic [AW-1:0] rd_addr;
   logic          rd_use;
   logic [NW-1:0] rd_next, rd_prev;
   logic          nw_en, nw_use, pw_en;
   logic [AW-1:0] nw_addr, pw_addr;
   logic [NW-1:0] nw_next, pw_prev;

   logic [NW-1:0] res_entry, res_head, res_next, res_prev;
   logic          rsp_free;

   dlpm_link_ram #(.POOL_DEPTH(POOL_DEPTH)) u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_use  (rd_use),
      .rd_next (rd_next),
      .rd_prev (rd_prev),
      .nw_en   (nw_en),
      .nw_addr (nw_addr),
      .nw_use  (nw_use),
      .nw_next (nw_next),
      .pw_en   (pw_en),
      .pw_addr (pw_addr),
      .pw_prev (pw_prev)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (state_ff)
         ST_IDLE:    rd_addr = req_head[AW-1:0];
         ST_RD_HEAD: rd_addr = tg_ff[AW-1:0];
         ST_RD_TGT:  rd_addr = free_head_ff[AW-1:0];
         ST_DECIDE:  rd_addr = eh_ff[AW-1:0];
         ST_WALK:    rd_addr = rd_next[AW-1:0];
         ST_RMW_RD:  rd_addr = mw_addr_ff[AW-1:0];
         default:    rd_addr = '0;
      endcase
   end

   always_comb begin
      nw_en   = 1'b0;
      nw_addr = '0;
      nw_use  = 1'b0;
      nw_next = NIL;
      pw_en   = 1'b0;
      pw_addr = '0;
      pw_prev = NIL;
      unique case (state_ff)
         ST_INIT: begin
            nw_en   = 1'b1;
            nw_addr = cnt_ff[AW-1:0];
            nw_next = cnt_ff + NW'(1);
            pw_en   = 1'b1;
            pw_addr = cnt_ff[AW-1:0];
         end
         ST_WR_R: begin
            nw_en   = 1'b1;
            nw_addr = r_ff[AW-1:0];
            nw_use  = 1'b1;
            nw_next = rnext_ff;
            pw_en   = 1'b1;
            pw_addr = r_ff[AW-1:0];
            pw_prev = rprev_ff;
         end
         ST_WR_P: begin
            pw_en   = 1'b1;
            pw_addr = pw_addr_ff[AW-1:0];
            pw_prev = pw_val_ff;
         end
         ST_RMW_WR: begin
            nw_en   = 1'b1;
            nw_addr = mw_addr_ff[AW-1:0];
            nw_use  = rd_use;
            nw_next = mw_val_ff;
         end
         ST_FREE_TG: begin
            nw_en   = 1'b1;
            nw_addr = tg_ff[AW-1:0];
            nw_next = free_head_ff;
            pw_en   = 1'b1;
            pw_addr = tg_ff[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res_entry = NIL;
      res_head  = eh_ff;
      res_next  = NIL;
      res_prev  = NIL;
      if (st_ff == STAT_OK) begin
         unique case (cmd_ff)
            CMD_ALLOC: res_entry = r_ff;
            CMD_PREPEND: begin
               res_entry = r_ff;
               res_head  = r_ff;
               res_next  = eh_ff;
            end
            CMD_APPEND: begin
               res_entry = r_ff;
               res_prev  = last_ff;
               res_head  = (last_ff < NIL) ? eh_ff : r_ff;
            end
            CMD_INS_BEFORE: begin
               res_entry = r_ff;
               res_next  = tg_ff;
               res_prev  = tp_ff;
               res_head  = (tp_ff < NIL) ? eh_ff : r_ff;
            end
            CMD_INS_AFTER: begin
               res_entry = r_ff;
               if (tok_ff) begin
                  res_next = tn_ff;
                  res_prev = tg_ff;
               end else begin
                  res_head = r_ff;
               end
            end
            CMD_FREE: begin
               res_entry = tg_ff;
               res_head  = (tp_ff < NIL) ? eh_ff : tn_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + NW'(1);
               if (cnt_ff == NIL - NW'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_cmd;
                  hd_ff    <= req_head;
                  tg_ff    <= req_target;
                  state_ff <= ST_RD_HEAD;
               end
            end
            ST_RD_HEAD: begin
               eh_ff    <= (hd_ff < NIL && rd_use) ? hd_ff : NIL;
               state_ff <= ST_RD_TGT;
            end
            ST_RD_TGT: begin
               tok_ff   <= (tg_ff < NIL) && rd_use;
               tn_ff    <= rd_next;
               tp_ff    <= rd_prev;
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               st_ff    <= STAT_OK;
               state_ff <= ST_DONE;
               if (cmd_ff <= CMD_INS_AFTER && free_head_ff == NIL) begin
                  st_ff <= STAT_EXHAUSTED;
               end else if ((cmd_ff == CMD_INS_BEFORE || cmd_ff == CMD_FREE) && !tok_ff) begin
                  st_ff <= STAT_BAD_TGT;
               end else if (cmd_ff <= CMD_FREE) begin
                  if (cmd_ff != CMD_FREE) begin
                     r_ff         <= free_head_ff;
                     free_head_ff <= rd_next;
                  end
                  rnext_ff <= NIL;
                  rprev_ff <= NIL;
                  state_ff <= ST_WR_R;
                  unique case (cmd_ff)
                     CMD_PREPEND: begin
                        rnext_ff   <= eh_ff;
                        pw_addr_ff <= eh_ff;
                        pw_val_ff  <= free_head_ff;
                     end
                     CMD_APPEND: begin
                        last_ff <= eh_ff;
                        cnt_ff  <= NW'(1);
                        if (eh_ff < NIL) begin
                           state_ff <= ST_WALK;
                        end
                     end
                     CMD_INS_BEFORE: begin
                        rnext_ff   <= tg_ff;
                        rprev_ff   <= tp_ff;
                        pw_addr_ff <= tg_ff;
                        pw_val_ff  <= free_head_ff;
                        mw_addr_ff <= tp_ff;
                        mw_val_ff  <= free_head_ff;
                     end
                     CMD_INS_AFTER: begin
                        if (tok_ff) begin
                           rnext_ff <= tn_ff;
                           rprev_ff <= tg_ff;
                        end
                        pw_addr_ff <= tn_ff;
                        pw_val_ff  <= free_head_ff;
                        mw_addr_ff <= tg_ff;
                        mw_val_ff  <= free_head_ff;
                     end
                     CMD_FREE: begin
                        pw_addr_ff <= tn_ff;
                        pw_val_ff  <= tp_ff;
                        mw_addr_ff <= tp_ff;
                        mw_val_ff  <= tn_ff;
                        priority if (tn_ff < NIL) begin
                           state_ff <= ST_WR_P;
                        end else if (tp_ff < NIL) begin
                           state_ff <= ST_RMW_RD;
                        end else begin
                           state_ff <= ST_FREE_TG;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_WALK: begin
               if (rd_next < NIL && cnt_ff < NIL) begin
                  last_ff <= rd_next;
                  cnt_ff  <= cnt_ff + NW'(1);
               end else begin
                  rprev_ff   <= last_ff;
                  mw_addr_ff <= last_ff;
                  mw_val_ff  <= r_ff;
                  state_ff   <= ST_WR_R;
               end
            end
            ST_WR_R: begin
               state_ff <= ST_DONE;
               unique case (cmd_ff)
                  CMD_PREPEND: begin
                     if (eh_ff < NIL) begin
                        state_ff <= ST_WR_P;
                     end
                  end
                  CMD_APPEND: begin
                     if (last_ff < NIL) begin
                        state_ff <= ST_RMW_RD;
                     end
                  end
                  CMD_INS_BEFORE: state_ff <= ST_WR_P;
                  CMD_INS_AFTER: begin
                     if (tok_ff) begin
                        state_ff <= (tn_ff < NIL) ? ST_WR_P : ST_RMW_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ST_WR_P: begin
               state_ff <= ST_DONE;
               unique case (cmd_ff)
                  CMD_INS_BEFORE: begin
                     if (tp_ff < NIL) begin
                        state_ff <= ST_RMW_RD;
                     end
                  end
                  CMD_INS_AFTER: state_ff <= ST_RMW_RD;
                  CMD_FREE: state_ff <= (tp_ff < NIL) ? ST_RMW_RD : ST_FREE_TG;
                  default: begin
                  end
               endcase
            end
            ST_RMW_RD: state_ff <= ST_RMW_WR;
            ST_RMW_WR: state_ff <= (cmd_ff == CMD_FREE) ? ST_FREE_TG : ST_DONE;
            ST_FREE_TG: begin
               free_head_ff <= tg_ff;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_entry_ff    <= res_entry;
                  rsp_new_head_ff <= res_head;
                  rsp_status_ff   <= st_ff;
                  rsp_next_ff     <= res_next;
                  rsp_prev_ff     <= res_prev;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_entry      = rsp_entry_ff;
   assign rsp_new_head   = rsp_new_head_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_next = rsp_next_ff;
   assign rsp_entry_prev = rsp_prev_ff;

`ifndef ASSERT_OFF
   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= NIL)
      else $error("free head out of range");

   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !req_ready)
      else $error("command accepted during clearing pass");

   a_fail_no_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_entry == NIL && rsp_entry_next == NIL && rsp_entry_prev == NIL))
      else $error("failed command reports an entry");

   a_exhausted_only_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_R) |-> (r_ff < NIL))
      else $error("link write to null entry");
`endif

endmodule

// ----- tb/doubly_linked_pool_manager_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_pool_manager_tb
// Self-checking bench: a shadow of the link tables predicts every response;
// directed cases, pool exhaustion, a long response stall and random list
// traffic run with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module doubly_linked_pool_manager_tb;
   import dlpm_pkg::*;

   localparam int DEPTH = 256;
   localparam logic [8:0] NIL = 9'd256;
   localparam int NLISTS = 4;

   typedef struct packed {
      logic [8:0] entry;
      logic [8:0] new_head;
      logic [1:0] status;
      logic [8:0] entry_next;
      logic [8:0] entry_prev;
   } pool_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_cmd = 3'd0;
   logic [8:0] req_head = 9'd0;
   logic [8:0] req_target = 9'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [8:0] rsp_entry, rsp_new_head, rsp_entry_next, rsp_entry_prev;
   logic [1:0] rsp_status;

   doubly_linked_pool_manager DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_head(req_head), .req_target(req_target),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_entry(rsp_entry),
      .rsp_new_head(rsp_new_head), .rsp_status(rsp_status),
      .rsp_entry_next(rsp_entry_next), .rsp_entry_prev(rsp_entry_prev)
   );

   always #5 clock = ~clock;

   // shadow of the pool
   logic [8:0] nxt_tbl [DEPTH];
   logic [8:0] prv_tbl [DEPTH];
   bit         used_tbl [DEPTH];
   logic [8:0] free_ptr;
   int         live_cnt;

   pool_rsp_type expected_rsps [$];
   logic [8:0] list_heads [NLISTS];
   logic [8:0] last_head;
   int         mismatches = 0;
   int         beats_sent = 0;
   int         beats_checked = 0;
   int         burst_left = 0;
   int         hold_off = 0;

   function automatic bit is_live(logic [8:0] i);
      return i < NIL && used_tbl[i[7:0]];
   endfunction

   function automatic logic [8:0] clip(logic [8:0] i);
      return i < NIL ? i : NIL;
   endfunction

   task automatic pool_reset();
      for (int i = 0; i < DEPTH; i++) begin
         nxt_tbl[i] = 9'(i + 1);
         prv_tbl[i] = NIL;
         used_tbl[i] = 0;
      end
      free_ptr = 9'd0;
      live_cnt = 0;
   endtask

   task automatic take_free(output logic [8:0] r);
      r = free_ptr;
      free_ptr = clip(nxt_tbl[r[7:0]]);
      used_tbl[r[7:0]] = 1;
      live_cnt++;
   endtask

   task automatic pool_apply(input logic [2:0] c, input logic [8:0] hd,
                             input logic [8:0] tg, output pool_rsp_type o);
      logic [8:0] eh, r, p, n, last;
      bit tok;
      int steps;
      eh = is_live(hd) ? hd : NIL;
      tok = is_live(tg);
      o = '{entry: NIL, new_head: eh, status: STAT_OK, entry_next: NIL, entry_prev: NIL};
      if (c <= CMD_INS_AFTER && free_ptr >= NIL) begin
         o.status = STAT_EXHAUSTED;
      end else if ((c == CMD_INS_BEFORE || c == CMD_FREE) && !tok) begin
         o.status = STAT_BAD_TGT;
      end else begin
         case (c)
            CMD_ALLOC: begin
               take_free(r);
               nxt_tbl[r[7:0]] = NIL;
               prv_tbl[r[7:0]] = NIL;
               o.entry = r;
            end
            CMD_PREPEND: begin
               take_free(r);
               nxt_tbl[r[7:0]] = eh;
               prv_tbl[r[7:0]] = NIL;
               if (eh < NIL) prv_tbl[eh[7:0]] = r;
               o.new_head = r;
               o.entry = r;
               o.entry_next = eh;
            end
            CMD_APPEND: begin
               last = NIL;
               n = eh;
               steps = 0;
               while (n < NIL && steps < DEPTH) begin
                  last = n;
                  n = nxt_tbl[n[7:0]];
                  steps++;
               end
               take_free(r);
               nxt_tbl[r[7:0]] = NIL;
               prv_tbl[r[7:0]] = last;
               if (last < NIL) nxt_tbl[last[7:0]] = r;
               else o.new_head = r;
               o.entry = r;
               o.entry_prev = last;
            end
            CMD_INS_BEFORE: begin
               take_free(r);
               p = clip(prv_tbl[tg[7:0]]);
               nxt_tbl[r[7:0]] = tg;
               prv_tbl[r[7:0]] = p;
               prv_tbl[tg[7:0]] = r;
               if (p < NIL) nxt_tbl[p[7:0]] = r;
               else o.new_head = r;
               o.entry = r;
               o.entry_next = tg;
               o.entry_prev = p;
            end
            CMD_INS_AFTER: begin
               take_free(r);
               if (!tok) begin
                  nxt_tbl[r[7:0]] = NIL;
                  prv_tbl[r[7:0]] = NIL;
                  o.new_head = r;
               end else begin
                  n = clip(nxt_tbl[tg[7:0]]);
                  nxt_tbl[r[7:0]] = n;
                  prv_tbl[r[7:0]] = tg;
                  if (n < NIL) prv_tbl[n[7:0]] = r;
                  nxt_tbl[tg[7:0]] = r;
                  o.entry_next = n;
                  o.entry_prev = tg;
               end
               o.entry = r;
            end
            CMD_FREE: begin
               n = clip(nxt_tbl[tg[7:0]]);
               p = clip(prv_tbl[tg[7:0]]);
               if (n < NIL) prv_tbl[n[7:0]] = p;
               if (p < NIL) nxt_tbl[p[7:0]] = n;
               else o.new_head = n;
               prv_tbl[tg[7:0]] = NIL;
               nxt_tbl[tg[7:0]] = free_ptr;
               used_tbl[tg[7:0]] = 0;
               free_ptr = tg;
               live_cnt--;
               o.entry = tg;
            end
            default: ;
         endcase
      end
   endtask

   // one request beat; valid stays up inside a burst
   task automatic send_cmd(input logic [2:0] c, input logic [8:0] hd, input logic [8:0] tg);
      pool_rsp_type o;
      bit rdy;
      req_cmd <= c;
      req_head <= hd;
      req_target <= tg;
      req_valid <= 1'b1;
      forever begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
         if (rdy) break;
      end
      pool_apply(c, hd, tg, o);
      expected_rsps.push_back(o);
      last_head = o.new_head;
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic sender_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      burst_left = 0;
   endtask

   task automatic drain();
      sender_idle();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // response side: stall pattern plus an optional long hold-off
   initial begin
      logic [15:0] pat;
      int cnt;
      pool_rsp_type got, exp_r;
      bit fire;
      pat = 16'hFFFF;
      cnt = 0;
      forever begin
         @(negedge clock);
         fire = rsp_valid && rsp_ready;
         got = '{rsp_entry, rsp_new_head, rsp_status, rsp_entry_next, rsp_entry_prev};
         @(posedge clock);
         if (fire) begin
            beats_checked++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat %p", got);
            end else begin
               exp_r = expected_rsps.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, actual %p", exp_r, got);
               end
            end
         end
         if (cnt % 64 == 0) pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
         cnt++;
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= pat[cnt % 16];
         end
      end
   end

   task automatic test_directed();
      logic [8:0] ha, t1;
      send_cmd(CMD_ALLOC, NIL, NIL);
      send_cmd(CMD_PREPEND, NIL, NIL);
      ha = last_head;
      send_cmd(CMD_APPEND, ha, NIL);
      t1 = ha;
      send_cmd(CMD_INS_BEFORE, ha, t1);
      ha = last_head;
      send_cmd(CMD_INS_AFTER, ha, t1);
      send_cmd(CMD_APPEND, ha, 9'd511);
      send_cmd(CMD_INS_AFTER, 9'd300, NIL);
      send_cmd(CMD_INS_AFTER, 9'd511, 9'd511);
      send_cmd(CMD_INS_BEFORE, ha, NIL);
      send_cmd(CMD_INS_BEFORE, ha, 9'd200);
      send_cmd(CMD_INS_BEFORE, ha, 9'd400);
      send_cmd(CMD_FREE, ha, 9'd2);
      send_cmd(CMD_FREE, ha, ha);
      ha = last_head;
      send_cmd(CMD_FREE, ha, 9'd250);
      send_cmd(CMD_FREE, ha, NIL);
      send_cmd(3'd6, ha, t1);
      send_cmd(3'd7, 9'd511, 9'd511);
      send_cmd(CMD_PREPEND, 9'd300, NIL);
      send_cmd(CMD_PREPEND, 9'd250, NIL);
      send_cmd(CMD_APPEND, 9'd0, NIL);
      send_cmd(CMD_FREE, 9'd511, 9'd0);
      drain();
   endtask

   task automatic free_everything();
      for (int i = 0; i < DEPTH; i++)
         if (used_tbl[i]) send_cmd(CMD_FREE, 9'($urandom_range(0, 511)), 9'(i));
      for (int l = 0; l < NLISTS; l++) list_heads[l] = NIL;
   endtask

   task automatic test_exhaustion();
      while (free_ptr < NIL) send_cmd(CMD_ALLOC, NIL, NIL);
      send_cmd(CMD_ALLOC, NIL, NIL);
      send_cmd(CMD_PREPEND, 9'd5, NIL);
      send_cmd(CMD_APPEND, 9'd7, NIL);
      send_cmd(CMD_INS_BEFORE, 9'd0, NIL);
      send_cmd(CMD_INS_AFTER, 9'd0, 9'd255);
      send_cmd(3'd6, 9'd3, 9'd3);
      free_everything();
      drain();
   endtask

   task automatic test_backpressure();
      hold_off = 400;
      for (int i = 0; i < 40; i++) send_cmd(CMD_PREPEND, list_heads[0], NIL) ;
      free_everything();
      drain();
   endtask

   // pick an entry of the list by walking a random distance
   function automatic logic [8:0] pick_member(logic [8:0] hd);
      logic [8:0] n;
      int k;
      n = hd;
      k = $urandom_range(0, 12);
      while (k > 0 && is_live(n) && is_live(nxt_tbl[n[7:0]])) begin
         n = nxt_tbl[n[7:0]];
         k--;
      end
      return n;
   endfunction

   task automatic test_random(input int n_items);
      int l, sel;
      logic [2:0] c;
      logic [8:0] hd, tg;
      bit tracked;
      for (int i = 0; i < n_items; i++) begin
         l = $urandom_range(0, NLISTS - 1);
         tracked = $urandom_range(0, 99) < 88;
         hd = tracked ? list_heads[l] : 9'($urandom());
         sel = $urandom_range(0, 99);
         if (sel < 3) c = 3'($urandom_range(6, 7));
         else if (live_cnt > 200 ? sel < 60 : sel < 25) c = CMD_FREE;
         else c = 3'($urandom_range(0, 4));
         sel = $urandom_range(0, 99);
         if (sel < 70) tg = pick_member(hd);
         else if (sel < 85) tg = 9'($urandom_range(0, 255));
         else tg = 9'($urandom());
         send_cmd(c, hd, tg);
         if (tracked) list_heads[l] = last_head;
      end
      drain();
   endtask

   initial begin
      #40ms;
      $display("doubly_linked_pool_manager regression: fail");
      $finish;
   end

   initial begin
      pool_reset();
      for (int l = 0; l < NLISTS; l++) list_heads[l] = NIL;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_exhaustion();
      test_backpressure();
      test_random(1400);
      if (expected_rsps.size() != 0) mismatches++;
      $display("covered %0d request beats, %0d response beats checked", beats_sent,
               beats_checked);
      $display("directed cases, pool exhaustion, long stall and random list traffic");
      if (mismatches == 0) begin
         $display("doubly_linked_pool_manager regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("doubly_linked_pool_manager regression: fail");
      end
      $finish;
   end

endmodule
